/* sv/adaptive_jitter_buffer_defines.svh */
// Assertion macros shared by the jitter buffer checker.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ADAPTIVE_JITTER_BUFFER_DEFINES_SVH
`define ADAPTIVE_JITTER_BUFFER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AJB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jitter buffer check failed");

// Next-cycle implication, checked outside reset.
`define AJB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jitter buffer check failed");

`endif

/* sv/ajb_pkg.sv */
// Types, codes and sizing constants for the adaptive jitter buffer.
// No dependencies; every other file but the defines header refers to it by scoped names.
package ajb_pkg;

  // Buffer geometry.
  localparam int DEPTH       = 16;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int PAYLOAD_MAX = 1024;
  localparam int HDR_BYTES   = 8;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Field widths fixed by the interface.
  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 11;
  localparam int SLOT_OUT_W = 4;
  localparam int CFG_OCC_W  = 5;
  localparam int TICK_W     = 16;
  localparam int MISS_W     = 8;
  localparam int CMP_W      = (OCC_W > CFG_OCC_W) ? OCC_W : CFG_OCC_W;

  // Register file addressing.
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_BUFFERED     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_BUFFERED     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DISCONNECT_TICKS = 2'd2;

  typedef enum logic [1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_PLAY    = 2'd1,
    KIND_START   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ACT_STORED       = 4'd0,
    ACT_LATE         = 4'd1,
    ACT_TOO_SMALL    = 4'd2,
    ACT_BEYOND       = 4'd3,
    ACT_SILENCE      = 4'd4,
    ACT_DECODE_PLAY  = 4'd5,
    ACT_CONCEAL_PLAY = 4'd6,
    ACT_DECODE_DROP  = 4'd7,
    ACT_CONCEAL_DROP = 4'd8,
    ACT_DISCONNECTED = 4'd9
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_PLAY_CHECK,
    ST_PLAY_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] packet_seq;
    logic [LEN_W-1:0] packet_bytes;
  } req_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SEQ_W-1:0]      seq;
    logic [LEN_W-1:0]      payload_len;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [CFG_OCC_W-1:0] min_buffered;
    logic [CFG_OCC_W-1:0] max_buffered;
    logic [TICK_W-1:0]    disconnect_ticks;
  } cfg_t;

endpackage

/* sv/ajb_regs.sv */
// Configuration registers of the jitter buffer behind an APB-style port.
// Depends on ajb_pkg for the register indexes and the cfg_t bundle.
module ajb_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ajb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ajb_pkg::cfg_t             cfg
);

  logic                            wr_en;
  logic [ajb_pkg::REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ajb_pkg::ADDR_W-1:2];

  // Register writes; unused addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_buffered     <= ajb_pkg::CFG_OCC_W'(2);
      cfg.max_buffered     <= ajb_pkg::CFG_OCC_W'(8);
      cfg.disconnect_ticks <= ajb_pkg::TICK_W'(250);
    end else if (wr_en) begin
      unique case (reg_idx)
        ajb_pkg::REG_MIN_BUFFERED:
          cfg.min_buffered <= pwdata[ajb_pkg::CFG_OCC_W-1:0];
        ajb_pkg::REG_MAX_BUFFERED:
          cfg.max_buffered <= pwdata[ajb_pkg::CFG_OCC_W-1:0];
        ajb_pkg::REG_DISCONNECT_TICKS:
          cfg.disconnect_ticks <= pwdata[ajb_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      ajb_pkg::REG_MIN_BUFFERED:     prdata = 32'(cfg.min_buffered);
      ajb_pkg::REG_MAX_BUFFERED:     prdata = 32'(cfg.max_buffered);
      ajb_pkg::REG_DISCONNECT_TICKS: prdata = 32'(cfg.disconnect_ticks);
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

/* sv/adaptive_jitter_buffer.sv */
// Timing: an arrival gives its one result from ST_ARRIVE; a play tick gives silence from
// ST_PLAY_CHECK, or its first decode/conceal result from ST_PLAY_EMIT after ST_PLAY_CHECK.
// Throughput: one item at a time; a play tick passes through ST_PLAY_CHECK (memory read),
// then ST_PLAY_EMIT (update) for each result, holding busy for up to sixteen results; the
// next request is taken once busy drops. Results cannot be stalled.
// Reset (synchronous): registers to defaults, no call, empty window via per-slot valid bits.
module adaptive_jitter_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ajb_pkg::req_t              request,
  output logic                       result_valid,
  output ajb_pkg::res_t              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ajb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int SW = ajb_pkg::SLOT_W;
  localparam int OW = ajb_pkg::OCC_W;
  localparam int CW = ajb_pkg::CMP_W;

  ajb_pkg::cfg_t   cfg;
  ajb_pkg::state_t state, state_next;
  ajb_pkg::req_t   req_q;

  logic [ajb_pkg::SEQ_W-1:0]  front_seq, front_seq_next;
  logic [OW-1:0]              occupied, occupied_next;
  logic [SW-1:0]              head, head_next;
  logic                       in_call, in_call_next;
  logic                       building, building_next;
  logic [ajb_pkg::MISS_W-1:0] missed_run, missed_run_next;
  logic [ajb_pkg::TICK_W-1:0] idle_ticks, idle_ticks_next;
  logic [ajb_pkg::DEPTH-1:0]  valid, valid_next;
  logic [ajb_pkg::CNT_W-1:0]  n_res, n_res_next;
  logic                       result_valid_next;
  ajb_pkg::res_t              result_next;
  logic                       clear_win;

  // Slot length memory, one write port and one registered read port.
  logic [ajb_pkg::LEN_W-1:0] mem [ajb_pkg::DEPTH];
  logic [ajb_pkg::LEN_W-1:0] rdata;
  logic                      mem_we;
  logic [SW-1:0]             mem_waddr;
  logic [ajb_pkg::LEN_W-1:0] mem_wdata;

  logic                       accept;
  logic [ajb_pkg::SEQ_W-1:0]  off;
  logic [SW-1:0]              off_s;
  logic [OW-1:0]              off_occ;
  logic [SW:0]                idx_sum;
  logic [SW-1:0]              idx;
  logic [ajb_pkg::LEN_W-1:0]  len_raw, len_cap;
  logic                       too_small, late, beyond;
  logic [ajb_pkg::DEPTH-1:0]  clr_mask;
  logic [CW-1:0]              occ_c, occ_new_c, minb_c, maxb_c;
  logic [OW-1:0]              occ_new;
  logic [ajb_pkg::CFG_OCC_W-1:0] maxb;
  logic                       hold_off, skip, present;
  logic [SW-1:0]              head_inc;
  logic [ajb_pkg::TICK_W-1:0] idle_inc;
  logic [ajb_pkg::MISS_W-1:0] miss_inc;

  ajb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = (state != ajb_pkg::ST_IDLE);
  assign accept = start && !busy;

  // The memory is written only while handling an arrival, and its read data is used only
  // in a play tick; busy keeps one request at a time, so the two never overlap on an entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[head];
  end

  // Arrival classification and slot placement.
  always_comb begin
    off       = req_q.packet_seq - front_seq;
    too_small = (req_q.packet_bytes <= ajb_pkg::LEN_W'(ajb_pkg::HDR_BYTES));
    late      = (req_q.packet_seq < front_seq);
    beyond    = (off >= ajb_pkg::SEQ_W'(ajb_pkg::DEPTH));
    off_s     = off[SW-1:0];
    off_occ   = OW'(off_s) + OW'(1);
    idx_sum   = {1'b0, head} + {1'b0, off_s};
    if (idx_sum >= (SW+1)'(ajb_pkg::DEPTH)) begin
      idx = SW'(idx_sum - (SW+1)'(ajb_pkg::DEPTH));
    end else begin
      idx = SW'(idx_sum);
    end
    len_raw = req_q.packet_bytes - ajb_pkg::LEN_W'(ajb_pkg::HDR_BYTES);
    if (len_raw > ajb_pkg::LEN_W'(ajb_pkg::PAYLOAD_MAX)) begin
      len_cap = ajb_pkg::LEN_W'(ajb_pkg::PAYLOAD_MAX);
    end else begin
      len_cap = len_raw;
    end
  end

  // Slots that a widening window passes over are emptied.
  always_comb begin
    logic [SW:0] rel;
    for (int j = 0; j < ajb_pkg::DEPTH; j++) begin
      if ((SW+1)'(j) >= {1'b0, head}) begin
        rel = (SW+1)'(j) - {1'b0, head};
      end else begin
        rel = (SW+1)'(j) + (SW+1)'(ajb_pkg::DEPTH) - {1'b0, head};
      end
      clr_mask[j] = ((SW+1)'(occupied) <= rel) && (rel <= {1'b0, off_s});
    end
  end

  // Play tick helpers.
  always_comb begin
    if (cfg.max_buffered < ajb_pkg::CFG_OCC_W'(2)) begin
      maxb = ajb_pkg::CFG_OCC_W'(2);
    end else begin
      maxb = cfg.max_buffered;
    end
    occ_new   = (occupied > OW'(1)) ? occupied - OW'(1) : occupied;
    occ_c     = CW'(occupied);
    occ_new_c = CW'(occ_new);
    minb_c    = CW'(cfg.min_buffered);
    maxb_c    = CW'(maxb);
    hold_off  = building && (occ_c < maxb_c);
    skip      = (occ_new_c >= maxb_c) &&
                (n_res != ajb_pkg::CNT_W'(ajb_pkg::MAX_RESULTS - 1));
    present   = valid[head];
    head_inc  = (head == SW'(ajb_pkg::DEPTH - 1)) ? '0 : head + SW'(1);
    idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + ajb_pkg::TICK_W'(1);
    miss_inc  = (missed_run == '1) ? missed_run : missed_run + ajb_pkg::MISS_W'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ajb_pkg::ST_IDLE: begin
        if (accept && in_call) begin
          if (request.kind == ajb_pkg::KIND_ARRIVAL) begin
            state_next = ajb_pkg::ST_ARRIVE;
          end else if (request.kind == ajb_pkg::KIND_PLAY) begin
            state_next = ajb_pkg::ST_PLAY_CHECK;
          end
        end
      end
      ajb_pkg::ST_ARRIVE: state_next = ajb_pkg::ST_IDLE;
      ajb_pkg::ST_PLAY_CHECK: begin
        state_next = hold_off ? ajb_pkg::ST_IDLE : ajb_pkg::ST_PLAY_EMIT;
      end
      ajb_pkg::ST_PLAY_EMIT: begin
        state_next = skip ? ajb_pkg::ST_PLAY_CHECK : ajb_pkg::ST_IDLE;
      end
      default: state_next = ajb_pkg::ST_IDLE;
    endcase
  end

  // Window update and result formation.
  always_comb begin
    front_seq_next    = front_seq;
    occupied_next     = occupied;
    head_next         = head;
    in_call_next      = in_call;
    building_next     = building;
    missed_run_next   = missed_run;
    idle_ticks_next   = idle_ticks;
    valid_next        = valid;
    n_res_next        = n_res;
    clear_win         = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = idx;
    mem_wdata         = len_cap;
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.seq   = front_seq;

    unique case (state)
      ajb_pkg::ST_IDLE: begin
        n_res_next = '0;
        if (accept && (request.kind == ajb_pkg::KIND_START)) begin
          clear_win    = 1'b1;
          in_call_next = 1'b1;
        end
      end

      ajb_pkg::ST_ARRIVE: begin
        result_valid_next = 1'b1;
        result_next.last  = 1'b1;
        result_next.seq   = req_q.packet_seq;
        priority if (too_small) begin
          result_next.action = ajb_pkg::ACT_TOO_SMALL;
        end else if (late) begin
          result_next.action = ajb_pkg::ACT_LATE;
        end else if (beyond) begin
          result_next.action = ajb_pkg::ACT_BEYOND;
        end else begin
          valid_next      = valid & ~clr_mask;
          valid_next[idx] = 1'b1;
          mem_we          = 1'b1;
          if (off_occ > occupied) begin
            occupied_next = off_occ;
          end
          result_next.action      = ajb_pkg::ACT_STORED;
          result_next.slot        = ajb_pkg::SLOT_OUT_W'(idx);
          result_next.payload_len = len_cap;
        end
      end

      ajb_pkg::ST_PLAY_CHECK: begin
        // Still building: silence, or a disconnect once the empty run is too long.
        if (hold_off) begin
          result_valid_next  = 1'b1;
          result_next.last   = 1'b1;
          result_next.action = ajb_pkg::ACT_SILENCE;
          if ((occupied == OW'(1)) && !present) begin
            idle_ticks_next = idle_inc;
            if (idle_inc > cfg.disconnect_ticks) begin
              result_next.action = ajb_pkg::ACT_DISCONNECTED;
              clear_win          = 1'b1;
              in_call_next       = 1'b0;
            end
          end else begin
            building_next = 1'b0;
          end
        end
      end

      ajb_pkg::ST_PLAY_EMIT: begin
        if (present) begin
          missed_run_next = '0;
          idle_ticks_next = '0;
        end else begin
          missed_run_next = miss_inc;
          if ((occ_c < minb_c) ||
              ((miss_inc > ajb_pkg::MISS_W'(1)) && (occ_c < maxb_c))) begin
            building_next = 1'b1;
          end
        end
        valid_next[head] = 1'b0;
        front_seq_next   = front_seq + ajb_pkg::SEQ_W'(1);
        if (occupied > OW'(1)) begin
          head_next     = head_inc;
          occupied_next = occ_new;
        end
        result_valid_next = 1'b1;
        result_next.last  = !skip;
        if (present) begin
          result_next.action      = skip ? ajb_pkg::ACT_DECODE_DROP
                                         : ajb_pkg::ACT_DECODE_PLAY;
          result_next.slot        = ajb_pkg::SLOT_OUT_W'(head);
          result_next.payload_len = rdata;
        end else begin
          result_next.action = skip ? ajb_pkg::ACT_CONCEAL_DROP
                                    : ajb_pkg::ACT_CONCEAL_PLAY;
        end
        n_res_next = n_res + ajb_pkg::CNT_W'(1);
      end

      default: ;
    endcase

    // Emptying the window overrides the window updates above.
    if (clear_win) begin
      valid_next      = '0;
      front_seq_next  = ajb_pkg::SEQ_W'(1);
      occupied_next   = OW'(1);
      head_next       = '0;
      building_next   = 1'b1;
      missed_run_next = '0;
      idle_ticks_next = '0;
    end
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ajb_pkg::ST_IDLE;
      front_seq    <= ajb_pkg::SEQ_W'(1);
      occupied     <= OW'(1);
      head         <= '0;
      in_call      <= 1'b0;
      building     <= 1'b1;
      missed_run   <= '0;
      idle_ticks   <= '0;
      valid        <= '0;
      n_res        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      front_seq    <= front_seq_next;
      occupied     <= occupied_next;
      head         <= head_next;
      in_call      <= in_call_next;
      building     <= building_next;
      missed_run   <= missed_run_next;
      idle_ticks   <= idle_ticks_next;
      valid        <= valid_next;
      n_res        <= n_res_next;
      result_valid <= result_valid_next;
    end
  end

  // Request capture and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    result <= result_next;
  end

endmodule

/* sv/ajb_checker.sv */
// Port-level checks of the jitter buffer's result sequencing, bound to the top level.
// Depends on ajb_pkg and the assertion macros in adaptive_jitter_buffer_defines.svh.
`include "adaptive_jitter_buffer_defines.svh"

module ajb_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          result_valid,
  input ajb_pkg::res_t result
);

  // A tick that still owes results keeps the block busy.
  `AJB_ASSERT_IMPL(a_more_means_busy, result_valid && !result.last, busy)

  // The final result of a request is shown as the block frees up.
  `AJB_ASSERT_IMPL(a_last_means_free, result_valid && result.last, !busy)

  // A newly accepted request never produces a result in the very next cycle.
  `AJB_ASSERT_NEXT(a_no_instant_result, start && !busy, !result_valid)

  // Only stored and decode results carry a slot and a length.
  `AJB_ASSERT_IMPL(a_quiet_fields,
    result_valid && (result.action != ajb_pkg::ACT_STORED) &&
    (result.action != ajb_pkg::ACT_DECODE_PLAY) &&
    (result.action != ajb_pkg::ACT_DECODE_DROP),
    (result.slot == '0) && (result.payload_len == '0))

endmodule

bind adaptive_jitter_buffer ajb_checker u_ajb_checker (.*);

/* bench/tb_adaptive_jitter_buffer.sv */
`timescale 1ns / 100ps
// Self-checking bench for the adaptive jitter buffer: a playout tracker predicts every action.
// Depends on ajb_pkg and the adaptive_jitter_buffer top level; needs nothing else.
module tb_adaptive_jitter_buffer;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 67;

  // Tracks the buffer window and holds the actions still owed by the block.
  class playout_tracker;
    logic [ajb_pkg::CFG_OCC_W-1:0] min_buf;
    logic [ajb_pkg::CFG_OCC_W-1:0] max_buf;
    logic [ajb_pkg::TICK_W-1:0]    disc_ticks;
    logic [ajb_pkg::SEQ_W-1:0]     front_seq;
    logic [ajb_pkg::LEN_W-1:0]     slot_len[ajb_pkg::DEPTH];
    int unsigned                   occupied;
    int unsigned                   head;
    int unsigned                   missed_run;
    int unsigned                   idle_ticks;
    bit                            in_call;
    bit                            building;
    ajb_pkg::res_t                 staged[$];
    ajb_pkg::res_t                 pending[$];
    int unsigned                   accepted, checked, failures, drops, disconnects;

    function new();
      min_buf = 5'd2;
      max_buf = 5'd8;
      disc_ticks = 16'd250;
      in_call = 1'b0;
      accepted = 0;
      checked = 0;
      failures = 0;
      drops = 0;
      disconnects = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (slot_len[i]) slot_len[i] = '0;
      front_seq = 32'd1;
      occupied = 1;
      head = 0;
      building = 1'b1;
      missed_run = 0;
      idle_ticks = 0;
    endfunction

    function void set_register(logic [ajb_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        ajb_pkg::REG_MIN_BUFFERED: min_buf = value[ajb_pkg::CFG_OCC_W-1:0];
        ajb_pkg::REG_MAX_BUFFERED: max_buf = value[ajb_pkg::CFG_OCC_W-1:0];
        ajb_pkg::REG_DISCONNECT_TICKS: disc_ticks = value[ajb_pkg::TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function void post(ajb_pkg::action_t act, int unsigned slot,
                       logic [ajb_pkg::SEQ_W-1:0] seq, int unsigned len);
      ajb_pkg::res_t e;
      e.action = act;
      e.slot = slot[ajb_pkg::SLOT_OUT_W-1:0];
      e.seq = seq;
      e.payload_len = len[ajb_pkg::LEN_W-1:0];
      e.last = 1'b0;
      staged.push_back(e);
    endfunction

    // Arrival checks run in order: too small, late, then beyond the window.
    function void arrival(logic [ajb_pkg::SEQ_W-1:0] seq, logic [ajb_pkg::LEN_W-1:0] bytes);
      logic [ajb_pkg::SEQ_W-1:0] off;
      int unsigned len, idx;
      if (bytes <= ajb_pkg::HDR_BYTES) begin
        post(ajb_pkg::ACT_TOO_SMALL, 0, seq, 0);
      end else if (seq < front_seq) begin
        post(ajb_pkg::ACT_LATE, 0, seq, 0);
      end else begin
        off = seq - front_seq;
        if (off >= ajb_pkg::DEPTH) begin
          post(ajb_pkg::ACT_BEYOND, 0, seq, 0);
        end else begin
          // Widen the window with empty slots up to this packet.
          for (int unsigned k = occupied; k <= off; k++)
            slot_len[(head + k) % ajb_pkg::DEPTH] = '0;
          if (off + 1 > occupied) occupied = off + 1;
          len = 32'(bytes) - 32'(ajb_pkg::HDR_BYTES);
          if (len > ajb_pkg::PAYLOAD_MAX) len = ajb_pkg::PAYLOAD_MAX;
          idx = (head + off) % ajb_pkg::DEPTH;
          slot_len[idx] = len[ajb_pkg::LEN_W-1:0];
          post(ajb_pkg::ACT_STORED, idx, seq, len);
        end
      end
    endfunction

    // One play tick: silence, disconnect, or a play preceded by skip-ahead drops.
    function void play_tick();
      int unsigned maxb, len, idx;
      logic [ajb_pkg::SEQ_W-1:0] seq_now;
      bit skip, done;
      maxb = (max_buf < 2) ? 2 : 32'(max_buf);
      done = 1'b0;
      while (!done) begin
        if (building && occupied < maxb) begin
          if (occupied == 1 && slot_len[head] == 0) begin
            if (idle_ticks < 16'hFFFF) idle_ticks++;
            if (idle_ticks > disc_ticks) begin
              post(ajb_pkg::ACT_DISCONNECTED, 0, front_seq, 0);
              clear_window();
              in_call = 1'b0;
              disconnects++;
              return;
            end
          end else begin
            building = 1'b0;
          end
          post(ajb_pkg::ACT_SILENCE, 0, front_seq, 0);
          return;
        end
        idx = head;
        seq_now = front_seq;
        len = 32'(slot_len[idx]);
        if (len != 0) begin
          missed_run = 0;
          idle_ticks = 0;
        end else begin
          if (missed_run < 255) missed_run++;
          if (occupied < min_buf || (missed_run > 1 && occupied < maxb)) building = 1'b1;
        end
        slot_len[idx] = '0;
        front_seq = front_seq + 32'd1;
        if (occupied > 1) begin
          head = (head + 1) % ajb_pkg::DEPTH;
          occupied--;
        end
        skip = (occupied >= maxb) && (staged.size() < ajb_pkg::MAX_RESULTS - 1);
        if (len != 0) begin
          if (skip) post(ajb_pkg::ACT_DECODE_DROP, idx, seq_now, len);
          else post(ajb_pkg::ACT_DECODE_PLAY, idx, seq_now, len);
        end else begin
          if (skip) post(ajb_pkg::ACT_CONCEAL_DROP, 0, seq_now, 0);
          else post(ajb_pkg::ACT_CONCEAL_PLAY, 0, seq_now, 0);
        end
        if (skip) drops++;
        done = !skip;
      end
    endfunction

    // Predicts the actions of one accepted request and queues them.
    function void note_request(ajb_pkg::req_t r);
      ajb_pkg::res_t tail;
      staged.delete();
      accepted++;
      if (r.kind == ajb_pkg::KIND_START) begin
        clear_window();
        in_call = 1'b1;
      end else if (in_call) begin
        if (r.kind == ajb_pkg::KIND_ARRIVAL) arrival(r.packet_seq, r.packet_bytes);
        else if (r.kind == ajb_pkg::KIND_PLAY) play_tick();
      end
      if (staged.size() > 0) begin
        tail = staged[staged.size() - 1];
        tail.last = 1'b1;
        staged[staged.size() - 1] = tail;
        foreach (staged[i]) pending.push_back(staged[i]);
      end
    endfunction

    // Compares one result from the block with the oldest predicted action.
    function void check_action(ajb_pkg::res_t got);
      ajb_pkg::res_t want;
      bit bad;
      if (pending.size() == 0) begin
        $error("result with none predicted: action %0d seq %0d", got.action, got.seq);
        failures++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      checked++;
      bad = 1'b0;
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        bad = 1'b1;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        bad = 1'b1;
      end
      if (got.seq !== want.seq) begin
        $error("seq: expected %0d, got %0d", want.seq, got.seq);
        bad = 1'b1;
      end
      if (got.payload_len !== want.payload_len) begin
        $error("payload_len: expected %0d, got %0d", want.payload_len, got.payload_len);
        bad = 1'b1;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        bad = 1'b1;
      end
      if (bad) failures++;
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  ajb_pkg::req_t              request = '0;
  logic                       result_valid;
  ajb_pkg::res_t              result;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ajb_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  playout_tracker tracker;
  int unsigned    idle_pct = 0;
  int unsigned    cycle_count = 0;

  // Register settings per random phase, extremes included.
  int unsigned min_plan[PHASES]  = '{1, 16, 4, 2, 8, 3};
  int unsigned max_plan[PHASES]  = '{2, 16, 6, 16, 4, 8};
  int unsigned disc_plan[PHASES] = '{1, 65535, 3, 10, 2, 40};
  int unsigned idle_plan[PHASES] = '{60, 0, 36, 60, 0, 36};

  adaptive_jitter_buffer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Results are checked at the edge that ends their cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) tracker.check_action(result);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adaptive_jitter_buffer test failed");
      $finish;
    end
  end

  function automatic ajb_pkg::req_t make_request(logic [1:0] k,
                                                 logic [ajb_pkg::SEQ_W-1:0] s,
                                                 logic [ajb_pkg::LEN_W-1:0] b);
    ajb_pkg::req_t r;
    r.kind = k;
    r.packet_seq = s;
    r.packet_bytes = b;
    return r;
  endfunction

  // Presents one request, with random sender gaps, and returns on the falling edge after
  // it has been accepted.
  task automatic send_request(ajb_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted action has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (tracker.pending.size() > 0);
  endtask

  // Writes a register, then reads it back.
  task automatic reg_write(logic [ajb_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, prdata);
      tracker.failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Edge cases under the reset settings.
  task automatic directed_part();
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd1, 11'd100));
    send_request(make_request(ajb_pkg::KIND_PLAY, 32'd0, 11'd0));
    send_request(make_request(KIND_UNUSED, 32'hFFFF_FFFF, 11'h7FF));
    send_request(make_request(ajb_pkg::KIND_START, 32'd0, 11'd0));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd5, 11'd0));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd1, 11'd8));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd0, 11'd100));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd17, 11'd100));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'hFFFF_FFFF, 11'h7FF));
    send_request(make_request(ajb_pkg::KIND_PLAY, 32'd0, 11'd0));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd1, 11'd9));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd16, 11'h7FF));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd3, 11'd1032));
    // A full window forces a long run of skip-ahead drops.
    repeat (5) send_request(make_request(ajb_pkg::KIND_PLAY, 32'd0, 11'd0));
    send_request(make_request(ajb_pkg::KIND_START, 32'd0, 11'd0));
    send_request(make_request(ajb_pkg::KIND_ARRIVAL, 32'd2, 11'd500));
    repeat (3) send_request(make_request(ajb_pkg::KIND_PLAY, 32'd0, 11'd0));
  endtask

  // Mostly plausible traffic around the current window, with some noise.
  task automatic random_phase(int unsigned count);
    ajb_pkg::req_t r;
    int unsigned sent, pick, sel, burst;
    bit counts;
    sent = 0;
    burst = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 2) wait_drained();
      r.kind = ajb_pkg::KIND_ARRIVAL;
      r.packet_seq = $urandom;
      r.packet_bytes = ajb_pkg::LEN_W'($urandom_range(ajb_pkg::HDR_BYTES + 1,
                                                      ajb_pkg::PAYLOAD_MAX + ajb_pkg::HDR_BYTES));
      pick = $urandom_range(99);
      if (!tracker.in_call) begin
        if (pick < 70) r.kind = ajb_pkg::KIND_START;
        else if (pick < 85) r.kind = ajb_pkg::KIND_PLAY;
      end else if (burst > 0) begin
        r.kind = ajb_pkg::KIND_PLAY;
        burst--;
      end else if (pick < 2) begin
        r.kind = ajb_pkg::KIND_START;
      end else if (pick < 4) begin
        r.kind = KIND_UNUSED;
      end else if (pick < 10) begin
        r.kind = ajb_pkg::KIND_PLAY;
        burst = $urandom_range(3, 20);
      end else if (pick < 50) begin
        r.kind = ajb_pkg::KIND_PLAY;
      end else begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          r.packet_seq = tracker.front_seq + $urandom_range(0, 3);
        end else if (sel < 70) begin
          r.packet_seq = tracker.front_seq + $urandom_range(0, ajb_pkg::DEPTH - 1);
        end else if (sel < 78) begin
          r.packet_seq = tracker.front_seq - $urandom_range(1, 20);
        end else if (sel < 88) begin
          r.packet_seq = tracker.front_seq + $urandom_range(ajb_pkg::DEPTH, 300);
        end
        sel = $urandom_range(99);
        if (sel < 8) begin
          r.packet_bytes = ajb_pkg::LEN_W'($urandom_range(0, ajb_pkg::HDR_BYTES));
        end else if (sel < 14) begin
          r.packet_bytes = ajb_pkg::LEN_W'($urandom_range(
              ajb_pkg::PAYLOAD_MAX + ajb_pkg::HDR_BYTES + 1, 2047));
        end
      end
      counts = (r.kind == ajb_pkg::KIND_START) ||
               (tracker.in_call && r.kind != KIND_UNUSED);
      send_request(r);
      if (counts) sent++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 0;
    directed_part();

    // Each phase starts from an idle block with fresh register settings.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clk);
      reg_write(ajb_pkg::REG_MIN_BUFFERED, min_plan[p]);
      reg_write(ajb_pkg::REG_MAX_BUFFERED, max_plan[p]);
      reg_write(ajb_pkg::REG_DISCONNECT_TICKS, disc_plan[p]);
      idle_pct = idle_plan[p];
      random_phase(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d predicted results never arrived", tracker.pending.size());
      tracker.failures++;
    end

    $display("Checked %0d results from %0d accepted requests over %0d register settings.",
             tracker.checked, tracker.accepted, PHASES + 1);
    $display("Skip-ahead drops seen: %0d; disconnects seen: %0d.",
             tracker.drops, tracker.disconnects);
    if (tracker.failures == 0) begin
      $display("adaptive_jitter_buffer test passed");
    end else begin
      $display("adaptive_jitter_buffer test failed");
    end
    $finish;
  end

endmodule
